// ===== design/sms_pkg.sv =====
// Package for the segmentation mask temporal smoother.
// Holds field widths, register indexes, pipeline stage positions and the fixed-point constants.
// No dependencies.
package sms_pkg;

    localparam int DEFAULT_MAX_PIXELS = 524288;

    localparam int LEVEL_W     = 16;
    localparam int FRAME_W     = 20;
    localparam int RATIO_W     = 17;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_PIXELS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_RATIO  = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_PIXELS_RESET = 20'd307200;
    localparam logic [RATIO_W-1:0] RATIO_ONE          = 17'd65536;

    localparam longint HALF_Q16 = 64'sd1 << 15;
    localparam longint HALF_Q24 = 64'sd1 << 23;
    localparam longint ONE_Q24  = 64'sd1 << 24;
    localparam longint HALF_Q30 = 64'sd1 << 29;

    // Level to Q1.30: p = level * 16448 + floor((64 * level + 127) / 255).
    localparam int     FRAC_P      = 30;
    localparam int     T_W         = 30;
    localparam int     NORM_IN_W   = 23;
    localparam int     RECIP_W     = 24;
    localparam int     RECIP_SHIFT = 31;
    localparam longint NORM_MULT   = 64'sd16448;
    localparam longint NORM_BIAS   = 64'sd127;
    localparam longint RECIP_255   = 64'sd8421505;

    localparam int X_W    = 29;
    localparam int ACC_W  = 36;
    localparam int AL_W   = 18;
    localparam int AH_W   = ACC_W - AL_W;
    localparam int LOHI_W = 30;
    localparam int W_W    = 25;
    localparam int PROD_W = 42;
    localparam int RES_W  = 20;

    localparam int HORNER_STEPS       = 5;
    localparam int FIRST_HORNER_STAGE = 3;
    localparam int W_STAGE            = FIRST_HORNER_STAGE + 2 * HORNER_STEPS;
    localparam int PROD_STAGE         = W_STAGE + 1;
    localparam int STAGES             = PROD_STAGE;

    localparam longint CF1 = (64'sd568842 * 64'sd16777216 + 64'sd50000) / 64'sd100000;
    localparam longint CF2 = -((64'sd748699 * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
    localparam longint CF3 = -((64'sd578051 * 64'sd16777216 + 64'sd5000) / 64'sd10000);
    localparam longint CF4 = (64'sd291309 * 64'sd16777216 + 64'sd500) / 64'sd1000;
    localparam longint CF5 = -((64'sd624717 * 64'sd16777216 + 64'sd500) / 64'sd1000);

    localparam logic signed [ACC_W-1:0] HORNER_INIT = ACC_W'(CF5);
    localparam logic signed [ACC_W-1:0] HORNER_ADD [HORNER_STEPS] =
        '{ACC_W'(CF4), ACC_W'(CF3), ACC_W'(CF2), ACC_W'(CF1), '0};

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               first_done;
        logic               last;
    } pix_meta_t;

endpackage

// ===== design/sms_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Reads return the old contents when the same address is written in that cycle.
// No dependencies.
module sms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/segmentation_mask_temporal_smoother.sv =====
// Segmentation mask temporal smoother, top level.
// Depends on sms_pkg and sms_ram.
//
// Mask pixels arrive in raster order as unsigned Q8.8 levels and leave as the same pixel blended
// with its value from the previous output frame, weighted by blend_ratio and by an uncertainty
// taken from a fifth-order polynomial in the square of the centred level. The block takes one
// pixel per clock while in_stall is low and delivers one result per pixel. The figure of one
// pixel per clock is set by the read-modify-write of the frame store, a MAX_PIXELS by 16 bit
// RAM with one write and one read port, whose latest two results are forwarded so that even a
// one-pixel frame runs at full rate. The input stall comes from a register: a two-entry output
// stage takes up a stall, so the pipeline keeps moving after the output stalls until one more
// result has reached it. The store is not cleared after reset; the first frame passes through
// unchanged and fills it. Configuration must be written while idle; the block itself does not
// enforce it.
module segmentation_mask_temporal_smoother
    import sms_pkg::*;
#(
    parameter int MAX_PIXELS = DEFAULT_MAX_PIXELS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [LEVEL_W-1:0]     mask_level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_W-1:0]     smoothed_level,
    output logic                   frame_end
);

    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CMP_W  = (ADDR_W > FRAME_W) ? ADDR_W + 1 : FRAME_W + 1;

    logic [FRAME_W-1:0] frame_pixels_reg;
    logic [RATIO_W-1:0] blend_ratio_reg;
    logic [ADDR_W-1:0]  pixel_position_reg;
    logic               first_frame_done_reg;

    logic               adv;
    logic               in_xfer;
    logic [CMP_W-1:0]   len_raw;
    logic [CMP_W-1:0]   len_eff;
    logic [CMP_W-1:0]   pos_inc;
    logic               last_next;
    logic [ADDR_W-1:0]  pixel_position_next;
    pix_meta_t          meta_next;

    logic [STAGES:1]    valid_reg;
    pix_meta_t          meta_reg [1:STAGES];
    logic [ADDR_W-1:0]  pos_reg [1:STAGES];

    logic [NORM_IN_W-1:0]         norm_in;
    logic [NORM_IN_W+RECIP_W-1:0] recip_prod;
    logic [T_W:0]                 norm_base;
    logic [T_W:0]                 p30;
    logic [T_W-1:0]               t_abs_next;
    logic [T_W-1:0]               t_abs_reg;

    logic [2*T_W-1:0] sq;
    logic [2*T_W:0]   x_sum;
    logic [X_W-1:0]   x_reg;

    logic [X_W-1:0]          xa_reg   [HORNER_STEPS];
    logic [X_W-1:0]          xb_reg   [HORNER_STEPS];
    logic signed [AH_W-1:0]  ah_reg   [HORNER_STEPS];
    logic [LOHI_W-1:0]       lohi_reg [HORNER_STEPS];
    logic signed [ACC_W-1:0] acc_reg  [HORNER_STEPS];

    logic signed [ACC_W-1:0]     cert;
    logic [W_W-1:0]              cert_cl;
    logic [W_W-1:0]              unc;
    logic [RATIO_W-1:0]          ratio_eff;
    logic [W_W+RATIO_W-1:0]      wprod;
    logic [W_W-1:0]              w_next;
    logic [W_W-1:0]              w_reg;

    logic [LEVEL_W-1:0]          ram_rd_data;
    logic [LEVEL_W-1:0]          prev_sel;
    logic signed [LEVEL_W:0]     diff;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_reg;

    logic signed [PROD_W:0]      rnd;
    logic signed [RES_W-1:0]     res_sum;
    logic [LEVEL_W-1:0]          res_level;
    logic                        pipe_out;

    logic                        wb_valid_reg;
    logic [ADDR_W-1:0]           wb_pos_reg;
    logic [LEVEL_W-1:0]          wb_level_reg;

    logic                        out_valid_reg;
    logic [LEVEL_W-1:0]          out_level_reg;
    logic                        out_end_reg;
    logic                        skid_valid_reg;
    logic [LEVEL_W-1:0]          skid_level_reg;
    logic                        skid_end_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pixels_reg <= FRAME_PIXELS_RESET;
            blend_ratio_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_PIXELS: frame_pixels_reg <= cfg_data[FRAME_W-1:0];
                REG_BLEND_RATIO:  blend_ratio_reg  <= cfg_data[RATIO_W-1:0];
            endcase
        end
    end

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign in_xfer  = in_valid && adv;

    // Frame position, updated on each input transfer.
    assign len_raw = (frame_pixels_reg == '0) ? CMP_W'(1) : CMP_W'(frame_pixels_reg);
    assign len_eff = (len_raw > CMP_W'(MAX_PIXELS)) ? CMP_W'(MAX_PIXELS) : len_raw;
    assign pos_inc = CMP_W'(pixel_position_reg) + CMP_W'(1);
    assign last_next = (pos_inc >= len_eff);
    assign pixel_position_next = last_next ? '0 : pos_inc[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_position_reg   <= '0;
            first_frame_done_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            pixel_position_reg <= pixel_position_next;
            if (last_next)
            begin
                first_frame_done_reg <= 1'b1;
            end
        end
    end

    assign meta_next = '{level: mask_level, first_done: first_frame_done_reg, last: last_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[STAGES-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            meta_reg[1] <= meta_next;
            pos_reg[1]  <= pixel_position_reg;
            for (int i = 2; i <= STAGES; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
                pos_reg[i]  <= pos_reg[i-1];
            end
        end
    end

    // Stage 1: normalise the level by 255 and centre it.
    assign norm_in    = {1'b0, mask_level, 6'd0} + NORM_IN_W'(NORM_BIAS);
    assign recip_prod = (NORM_IN_W+RECIP_W)'(norm_in) * (NORM_IN_W+RECIP_W)'(RECIP_255);
    assign norm_base  = (T_W+1)'(mask_level) * (T_W+1)'(NORM_MULT);
    assign p30        = norm_base + (T_W+1)'(recip_prod[RECIP_SHIFT +: LEVEL_W]);
    assign t_abs_next = (p30 >= (T_W+1)'(HALF_Q30)) ? T_W'(p30 - (T_W+1)'(HALF_Q30))
                                                     : T_W'((T_W+1)'(HALF_Q30) - p30);

    // Stage 2: square.
    assign sq    = t_abs_reg * t_abs_reg;
    assign x_sum = {1'b0, sq} + (2*T_W+1)'(HALF_Q30);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_abs_reg <= t_abs_next;
            x_reg     <= x_sum[FRAC_P +: X_W];
        end
    end

    // Horner steps, two stages each: the low partial product, then the high one with the
    // coefficient added.
    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_horner
        logic signed [ACC_W-1:0]       acc_in;
        logic [X_W-1:0]                x_in;
        logic [AL_W+X_W:0]             lo_sum;
        logic signed [AH_W+X_W:0]      hi_prod;
        logic signed [AH_W+X_W+1:0]    hi_sum;
        logic signed [ACC_W-1:0]       acc_next;

        if (j == 0)
        begin : g_first
            assign acc_in = HORNER_INIT;
            assign x_in   = x_reg;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[j-1];
            assign x_in   = xb_reg[j-1];
        end

        assign lo_sum  = (AL_W+X_W+1)'(acc_in[AL_W-1:0]) * (AL_W+X_W+1)'(x_in)
                       + (AL_W+X_W+1)'(HALF_Q30);
        assign hi_prod = ah_reg[j] * $signed({1'b0, xa_reg[j]});
        assign hi_sum  = (AH_W+X_W+2)'(hi_prod) + $signed((AH_W+X_W+2)'(lohi_reg[j]));
        assign acc_next = ACC_W'($signed(hi_sum[AH_W+X_W+1:FRAC_P-AL_W])) + HORNER_ADD[j];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ah_reg[j]   <= acc_in[ACC_W-1:AL_W];
                lohi_reg[j] <= lo_sum[AL_W +: LOHI_W];
                xa_reg[j]   <= x_in;
                acc_reg[j]  <= acc_next;
                xb_reg[j]   <= xa_reg[j];
            end
        end
    end

    // Stage 13: clamp the certainty and weight the uncertainty by the ratio.
    assign cert = acc_reg[HORNER_STEPS-1];

    always_comb
    begin
        if (cert[ACC_W-1])
        begin
            cert_cl = '0;
        end
        else if (cert > $signed(ACC_W'(ONE_Q24)))
        begin
            cert_cl = W_W'(ONE_Q24);
        end
        else
        begin
            cert_cl = cert[W_W-1:0];
        end
    end

    assign unc       = W_W'(ONE_Q24) - cert_cl;
    assign ratio_eff = (blend_ratio_reg > RATIO_ONE) ? RATIO_ONE : blend_ratio_reg;
    assign wprod     = (W_W+RATIO_W)'(unc) * (W_W+RATIO_W)'(ratio_eff) + (W_W+RATIO_W)'(HALF_Q16);
    assign w_next    = wprod[16 +: W_W];

    // Stage 14: previous value, forwarded from the two newest results where the position matches.
    always_comb
    begin
        if (valid_reg[PROD_STAGE] && (pos_reg[PROD_STAGE] == pos_reg[W_STAGE]))
        begin
            prev_sel = res_level;
        end
        else if (wb_valid_reg && (wb_pos_reg == pos_reg[W_STAGE]))
        begin
            prev_sel = wb_level_reg;
        end
        else
        begin
            prev_sel = ram_rd_data;
        end
    end

    assign diff = meta_reg[W_STAGE].first_done
                ? $signed({1'b0, prev_sel}) - $signed({1'b0, meta_reg[W_STAGE].level})
                : '0;
    assign prod_next = PROD_W'(diff * $signed({1'b0, w_reg}));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg    <= w_next;
            prod_reg <= prod_next;
        end
    end

    // Result: round, add and saturate.
    assign rnd     = (PROD_W+1)'(prod_reg) + $signed((PROD_W+1)'(HALF_Q24));
    assign res_sum = $signed(RES_W'(meta_reg[PROD_STAGE].level))
                   + RES_W'($signed(rnd[PROD_W:24]));

    always_comb
    begin
        if (res_sum[RES_W-1])
        begin
            res_level = '0;
        end
        else if (res_sum[RES_W-2:LEVEL_W] != '0)
        begin
            res_level = '1;
        end
        else
        begin
            res_level = res_sum[LEVEL_W-1:0];
        end
    end

    assign pipe_out = valid_reg[PROD_STAGE] && adv;

    sms_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk     (clk),
        .wr_en   (pipe_out),
        .wr_addr (pos_reg[PROD_STAGE]),
        .wr_data (res_level),
        .rd_en   (adv),
        .rd_addr (pos_reg[W_STAGE-1]),
        .rd_data (ram_rd_data)
    );

    // The result written in the same cycle as a read is missed by that read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            wb_valid_reg <= valid_reg[PROD_STAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wb_pos_reg   <= pos_reg[PROD_STAGE];
            wb_level_reg <= res_level;
        end
    end

    // Output register and skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_out;
            end
        end
        else if (pipe_out)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_level_reg <= skid_level_reg;
                out_end_reg   <= skid_end_reg;
            end
            else
            begin
                out_level_reg <= res_level;
                out_end_reg   <= meta_reg[PROD_STAGE].last;
            end
        end
        else if (pipe_out)
        begin
            skid_level_reg <= res_level;
            skid_end_reg   <= meta_reg[PROD_STAGE].last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign smoothed_level = out_level_reg;
    assign frame_end      = out_end_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry holds a result while the output register is empty.");

    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("Skid entry dropped while the output was stalled.");

    a_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(first_frame_done_reg) |-> $past(in_xfer && last_next))
        else $error("First frame marked done without a transfer of its last pixel.");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(pixel_position_reg) < CMP_W'(MAX_PIXELS))
        else $error("Pixel position beyond the frame store.");

endmodule

// ===== dv/segmentation_mask_temporal_smoother_tb.sv =====
// Self-checking testbench for segmentation_mask_temporal_smoother.
// Streams mask pixels through the block, predicts each smoothed pixel and compares in order.
// Depends on sms_pkg and the design files of the block.
`timescale 1ns / 100ps

module segmentation_mask_temporal_smoother_tb
    import sms_pkg::*;
();

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_SETTING = 95;

    localparam longint HORN_C1 = (64'sd568842 * 64'sd16777216 + 64'sd50000) / 64'sd100000;
    localparam longint HORN_C2 = -((64'sd748699 * 64'sd16777216 + 64'sd500000) / 64'sd1000000);
    localparam longint HORN_C3 = -((64'sd578051 * 64'sd16777216 + 64'sd5000) / 64'sd10000);
    localparam longint HORN_C4 = (64'sd291309 * 64'sd16777216 + 64'sd500) / 64'sd1000;
    localparam longint HORN_C5 = -((64'sd624717 * 64'sd16777216 + 64'sd500) / 64'sd1000);
    localparam longint CERT_ONE = 64'sd1 <<< 24;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               last;
    } smoothed_pix_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [LEVEL_W-1:0]     mask_level = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [LEVEL_W-1:0]     smoothed_level;
    logic                   frame_end;

    logic [LEVEL_W-1:0] pending_levels [$];
    smoothed_pix_t      expected_pixels [$];
    smoothed_pix_t      oldest_pixel;

    logic [FRAME_W-1:0] frame_cfg = FRAME_PIXELS_RESET;
    logic [RATIO_W-1:0] blend_cfg = '0;
    logic [LEVEL_W-1:0] prev_frame [int];
    int                 pix_pos = 0;
    bit                 frame_done = 1'b0;
    int                 frame_extent = 0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    segmentation_mask_temporal_smoother u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mask_level     (mask_level),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .smoothed_level (smoothed_level),
        .frame_end      (frame_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint round_shift_q(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [LEVEL_W-1:0] random_level();
        logic [LEVEL_W-1:0] lvl;
        case ($urandom_range(7))
            0: lvl = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1: lvl = LEVEL_W'($urandom_range(65280, 63000));
            2: lvl = LEVEL_W'($urandom_range(33152, 32128));
            default: lvl = LEVEL_W'($urandom_range(65535));
        endcase
        return lvl;
    endfunction

    // Works out the smoothed pixel for one level and queues the level for the driver.
    task automatic queue_pixel(logic [LEVEL_W-1:0] lvl);
        longint        p30, t30, x30, acc, cert, unc, ratio, wgt, prev, res, len;
        smoothed_pix_t want;
        p30 = ((longint'(lvl) <<< 30) + 64'sd32640) / 64'sd65280;
        t30 = p30 - (64'sd1 <<< 29);
        x30 = (t30 * t30 + (64'sd1 <<< 29)) >>> 30;
        acc = HORN_C5;
        acc = HORN_C4 + round_shift_q(acc * x30, 30);
        acc = HORN_C3 + round_shift_q(acc * x30, 30);
        acc = HORN_C2 + round_shift_q(acc * x30, 30);
        acc = HORN_C1 + round_shift_q(acc * x30, 30);
        cert = round_shift_q(acc * x30, 30);
        if (cert > CERT_ONE)
            cert = CERT_ONE;
        if (cert < 0)
            cert = 0;
        unc = CERT_ONE - cert;
        ratio = (blend_cfg > RATIO_ONE) ? longint'(RATIO_ONE) : longint'(blend_cfg);
        len = (frame_cfg == 0) ? 1 : longint'(frame_cfg);
        if (len > DEFAULT_MAX_PIXELS)
            len = DEFAULT_MAX_PIXELS;
        prev = frame_done ? longint'(prev_frame[pix_pos]) : longint'(lvl);
        wgt = round_shift_q(unc * ratio, 16);
        res = longint'(lvl) + round_shift_q((prev - longint'(lvl)) * wgt, 24);
        if (res < 0)
            res = 0;
        if (res > 65535)
            res = 65535;
        prev_frame[pix_pos] = res[LEVEL_W-1:0];
        if (pix_pos + 1 > frame_extent)
            frame_extent = pix_pos + 1;
        want.level = res[LEVEL_W-1:0];
        want.last = (pix_pos + 1 >= len);
        if (want.last)
        begin
            pix_pos = 0;
            frame_done = 1'b1;
        end
        else
        begin
            pix_pos = pix_pos + 1;
        end
        expected_pixels = {expected_pixels, want};
        pending_levels = {pending_levels, lvl};
    endtask

    task automatic wait_until_idle();
        while (pending_levels.size() != 0 || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_until_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_FRAME_PIXELS)
            frame_cfg = val[FRAME_W-1:0];
        else
            blend_cfg = val[RATIO_W-1:0];
    endtask

    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pending_levels.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                mask_level <= pending_levels.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("Unexpected transfer: smoothed_level %0d frame_end %0b",
                             smoothed_level, frame_end);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                oldest_pixel = expected_pixels.pop_front();
                if (smoothed_level !== oldest_pixel.level || frame_end !== oldest_pixel.last)
                begin
                    if (mismatch_count < 10)
                        $display("Mismatch: expected level %0d end %0b, got level %0d end %0b",
                                 oldest_pixel.level, oldest_pixel.last,
                                 smoothed_level, frame_end);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        int ph;
        int half;
        int n;
        int pick;
        logic [CFG_DATA_W-1:0] val;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // The first frame passes through and fills the store; it runs with the reset length,
        // then the largest lengths, and is ended by a shorter length written mid-frame.
        queue_pixel(16'd0);
        queue_pixel(16'd65535);
        queue_pixel(16'd32640);
        write_reg(REG_FRAME_PIXELS, CFG_DATA_W'(DEFAULT_MAX_PIXELS));
        queue_pixel(16'd65280);
        queue_pixel(16'd1);
        write_reg(REG_FRAME_PIXELS, 20'hFFFFF);
        queue_pixel(16'd65534);
        queue_pixel(16'd128);
        for (n = 0; n < 40; n++)
            queue_pixel(random_level());
        write_reg(REG_FRAME_PIXELS, 20'd4);
        queue_pixel(16'd16320);

        write_reg(REG_BLEND_RATIO, CFG_DATA_W'(RATIO_ONE));
        queue_pixel(16'd0);
        queue_pixel(16'd65535);
        queue_pixel(16'd32640);
        queue_pixel(16'd65280);
        queue_pixel(16'd1);
        queue_pixel(16'd65534);
        queue_pixel(16'd16320);
        queue_pixel(16'd48960);
        write_reg(REG_BLEND_RATIO, 20'd131071);
        queue_pixel(16'd65535);
        queue_pixel(16'd0);
        queue_pixel(16'd32768);
        queue_pixel(16'd200);
        write_reg(REG_FRAME_PIXELS, 20'd0);
        queue_pixel(16'd65535);
        queue_pixel(16'd0);
        queue_pixel(16'd40000);
        write_reg(REG_BLEND_RATIO, 20'd0);
        queue_pixel(16'd12345);
        queue_pixel(16'd54321);

        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_until_idle();
            case (ph % 4)
                0:
                begin
                    send_idle_pct <= 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct <= 83;
                    stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct <= 0;
                    stall_pct <= 83;
                end
                default:
                begin
                    send_idle_pct <= 21;
                    stall_pct <= 21;
                end
            endcase
            for (half = 0; half < 2; half++)
            begin
                pick = $urandom_range(7);
                if (pick == 0)
                    val = '0;
                else if (pick == 1)
                    val = CFG_DATA_W'(frame_extent);
                else
                    val = CFG_DATA_W'($urandom_range((frame_extent < 16) ? frame_extent : 16, 1));
                write_reg(REG_FRAME_PIXELS, val);
                case ($urandom_range(5))
                    0: val = '0;
                    1: val = CFG_DATA_W'(RATIO_ONE);
                    2: val = CFG_DATA_W'($urandom_range(131071, 65537));
                    default: val = CFG_DATA_W'($urandom_range(65535));
                endcase
                write_reg(REG_BLEND_RATIO, val);
                for (n = 0; n < ITEMS_PER_SETTING; n++)
                    queue_pixel(random_level());
            end
        end

        wait_until_idle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
